// ----- src/sum_segment_tree_defines.svh -----
// assertion macros of the segment tree sources, included by sst_ctrl
`ifndef SUM_SEGMENT_TREE_DEFINES_SVH
`define SUM_SEGMENT_TREE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SST_ASSERT_NORST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SST_ASSERT(label, prop, msg)
`define SST_ASSERT_NORST(label, prop, msg)
`endif
`endif

// ----- src/sst_pkg.sv -----
// shared constants, codes and types of the segment tree
package sst_pkg;

   localparam int unsigned LEAVES   = 1024;
   localparam int unsigned NODE_CNT = 2 * LEAVES;
   localparam int unsigned NODE_W   = $clog2(NODE_CNT);
   localparam int unsigned IDX_W    = NODE_W + 1;
   localparam int unsigned POS_W    = 10;
   localparam int unsigned VAL_W    = 32;
   localparam int unsigned SUM_W    = 64;

   localparam logic ACT_SET   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLR,
      ST_IDLE,
      ST_SET_RD,
      ST_SET_ADD,
      ST_QRY_A,
      ST_QRY_B
   } state_type;

   typedef enum logic [1:0] {
      WSRC_ZERO,
      WSRC_VALUE,
      WSRC_SUM
   } wsrc_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_CLEAR,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      wsrc_type          wsrc;
      logic              re;
      logic [NODE_W-1:0] raddr;
   } mem_cmd_type;

   typedef struct packed {
      acc_op_type op;
      logic       done;
   } acc_cmd_type;

endpackage

// ----- src/sst_ram.sv -----
// node sum memory, one write port and one registered read port
module sst_ram (
   input  logic                       clock,
   input  logic                       we,
   input  logic [sst_pkg::NODE_W-1:0] waddr,
   input  logic [sst_pkg::SUM_W-1:0]  wdata,
   input  logic                       re,
   input  logic [sst_pkg::NODE_W-1:0] raddr,
   output logic [sst_pkg::SUM_W-1:0]  rdata
);
   import sst_pkg::*;

   logic [SUM_W-1:0] mem_ff [NODE_CNT];
   logic [SUM_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/sst_alu.sv -----
// shared 64-bit adder with its accumulator register
module sst_alu (
   input  logic                      clock,
   input  sst_pkg::acc_op_type       op,
   input  logic [sst_pkg::VAL_W-1:0] value,
   input  logic [sst_pkg::SUM_W-1:0] rdata,
   output logic [sst_pkg::SUM_W-1:0] add_sum,
   output logic [sst_pkg::SUM_W-1:0] acc_next
);
   import sst_pkg::*;

   logic [SUM_W-1:0] acc_ff;
   logic [SUM_W-1:0] acc_in;

   assign add_sum = acc_ff + rdata;

   always_comb begin
      case (op)
         ACC_LOAD:  acc_in = SUM_W'(value);
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = add_sum;
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_next = acc_in;

endmodule

// ----- src/sst_ctrl.sv -----
// sequencer: clearing pass, leaf-to-root update walk and range walk
`include "sum_segment_tree_defines.svh"
module sst_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      action,
   input  logic [sst_pkg::POS_W-1:0] position,
   input  logic [sst_pkg::POS_W-1:0] range_low,
   input  logic [sst_pkg::POS_W-1:0] range_high,
   output logic                      busy,
   output sst_pkg::mem_cmd_type      mem_cmd,
   output sst_pkg::acc_cmd_type      acc_cmd
);
   import sst_pkg::*;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic [IDX_W-1:0]  b_ff, b_in;
   logic              pend_ff, pend_in;

   logic              accept;
   logic              set_ok;
   logic [NODE_W-1:0] leaf_k;
   logic [NODE_W-1:0] parent;
   logic [IDX_W-1:0]  hi_clamp;
   logic [IDX_W-1:0]  a_start;
   logic [IDX_W-1:0]  b_start;
   logic [IDX_W-1:0]  b_dec;
   logic              a_lt_b;
   logic              clr_last;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && (state_ff == ST_IDLE);
   assign set_ok   = IDX_W'(position) < IDX_W'(LEAVES);
   assign leaf_k   = NODE_W'(IDX_W'(position) + IDX_W'(LEAVES));
   assign parent   = k_ff >> 1;
   assign hi_clamp = (IDX_W'(range_high) >= IDX_W'(LEAVES)) ? IDX_W'(LEAVES - 1)
                                                            : IDX_W'(range_high);
   assign a_start  = IDX_W'(range_low) + IDX_W'(LEAVES);
   assign b_start  = hi_clamp + IDX_W'(LEAVES) + IDX_W'(1);
   assign b_dec    = b_ff - IDX_W'(1);
   assign a_lt_b   = a_ff < b_ff;
   assign clr_last = (clr_ff == NODE_W'(NODE_CNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (action == ACT_QUERY) state_in = ST_QRY_A;
               else if (set_ok)         state_in = ST_SET_RD;
            end
         end
         ST_SET_RD:  state_in = ST_SET_ADD;
         ST_SET_ADD: state_in = (parent == NODE_W'(1)) ? ST_IDLE : ST_SET_RD;
         ST_QRY_A:   state_in = a_lt_b ? ST_QRY_B : ST_IDLE;
         ST_QRY_B:   state_in = ST_QRY_A;
         default:    state_in = ST_IDLE;
      endcase
   end

   // walk indexes
   always_comb begin
      clr_in  = clr_ff;
      k_in    = k_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pend_in = mem_cmd.re;
      case (state_ff)
         ST_CLR: clr_in = clr_ff + NODE_W'(1);
         ST_IDLE: begin
            if (accept) begin
               k_in = leaf_k;
               a_in = a_start;
               b_in = b_start;
            end
         end
         ST_SET_ADD: k_in = parent;
         ST_QRY_A: begin
            if (a_lt_b && a_ff[0]) a_in = a_ff + IDX_W'(1);
         end
         ST_QRY_B: begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      mem_cmd       = '0;
      mem_cmd.wsrc  = WSRC_ZERO;
      acc_cmd.op    = ACC_HOLD;
      acc_cmd.done  = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = clr_ff;
         end
         ST_IDLE: begin
            if (accept && action == ACT_QUERY) begin
               acc_cmd.op = ACC_CLEAR;
            end else if (accept && set_ok) begin
               mem_cmd.we    = 1'b1;
               mem_cmd.waddr = leaf_k;
               mem_cmd.wsrc  = WSRC_VALUE;
               acc_cmd.op    = ACC_LOAD;
            end
         end
         ST_SET_RD: begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = k_ff ^ NODE_W'(1);
         end
         ST_SET_ADD: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = parent;
            mem_cmd.wsrc  = WSRC_SUM;
            acc_cmd.op    = ACC_ADD;
         end
         ST_QRY_A: begin
            if (pend_ff) acc_cmd.op = ACC_ADD;
            if (a_lt_b && a_ff[0]) begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = a_ff[NODE_W-1:0];
            end
            if (!a_lt_b) acc_cmd.done = 1'b1;
         end
         ST_QRY_B: begin
            if (pend_ff) acc_cmd.op = ACC_ADD;
            if (b_ff[0]) begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = b_dec[NODE_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   `SST_ASSERT_NORST(a_busy_after_reset, reset |=> busy, "block not busy after reset")
   `SST_ASSERT(a_set_walk_below_root, state_ff == ST_SET_RD |-> k_ff > NODE_W'(1), "update walk at root")
   `SST_ASSERT(a_pend_from_read, pend_ff |-> $past(mem_cmd.re), "pending add without a read")
   `SST_ASSERT(a_qry_order, state_ff == ST_QRY_B |-> a_ff <= b_ff, "range walk crossed over")

endmodule

// ----- src/sum_segment_tree.sv -----
// top level of the segment tree of 64-bit range sums
// after reset the block is busy while a clearing pass zeroes every node
// a set beat writes the leaf, then on each level reads the sibling and adds+writes the parent
// a query beat walks up from both range ends; no new beat is taken until a walk is over
// the walks are paced by the single read port of the node memory, at most one read each level and side
// rsp_valid rises in the cycle after the walk ends and lasts one cycle; the receiver cannot stall
module sum_segment_tree (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [sst_pkg::POS_W-1:0] req_position,
   input  logic [sst_pkg::VAL_W-1:0] req_value,
   input  logic [sst_pkg::POS_W-1:0] req_range_low,
   input  logic [sst_pkg::POS_W-1:0] req_range_high,
   output logic                      rsp_valid,
   output logic [sst_pkg::SUM_W-1:0] rsp_sum
);
   import sst_pkg::*;

   mem_cmd_type      mem_cmd;
   acc_cmd_type      acc_cmd;
   logic [SUM_W-1:0] mem_wdata;
   logic [SUM_W-1:0] mem_rdata;
   logic [SUM_W-1:0] add_sum;
   logic [SUM_W-1:0] acc_next;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   // sequencer: owns the walk indexes and steers memory and adder
   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_action),
      .position   (req_position),
      .range_low  (req_range_low),
      .range_high (req_range_high),
      .busy       (busy),
      .mem_cmd    (mem_cmd),
      .acc_cmd    (acc_cmd)
   );

   // write data: zero during the clearing pass, the new leaf value on the
   // accepted set beat, the running sum while walking up to the root
   always_comb begin
      case (mem_cmd.wsrc)
         WSRC_VALUE: mem_wdata = SUM_W'(req_value);
         WSRC_SUM:   mem_wdata = add_sum;
         default:    mem_wdata = '0;
      endcase
   end

   // node sums, node 1 is the root and leaf p lives at node LEAVES+p
   sst_ram u_ram (
      .clock (clock),
      .we    (mem_cmd.we),
      .waddr (mem_cmd.waddr),
      .wdata (mem_wdata),
      .re    (mem_cmd.re),
      .raddr (mem_cmd.raddr),
      .rdata (mem_rdata)
   );

   // the one adder: accumulator plus the node just read
   sst_alu u_alu (
      .clock    (clock),
      .op       (acc_cmd.op),
      .value    (req_value),
      .rdata    (mem_rdata),
      .add_sum  (add_sum),
      .acc_next (acc_next)
   );

   // result register, loaded with the final sum including any last pending add
   assign rsp_valid_in = acc_cmd.done;
   assign rsp_sum_in   = acc_cmd.done ? acc_next : rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

endmodule

// ----- dv/sum_segment_tree_tb.sv -----
// self-checking testbench of the segment tree range-sum block: directed and random set/query beats
module sum_segment_tree_tb;
   import sst_pkg::*;

   localparam int unsigned CLK_HALF     = 5;
   localparam int unsigned RESET_CYCLES = 10;
   localparam int unsigned RANDOM_BEATS = 950;
   // the drain covers the longest query walk with margin
   localparam int unsigned DRAIN_CYCLES = 40;
   // clearing pass + ~970 beats * (busy time + longest gap), taken several times over
   localparam int unsigned CYCLE_LIMIT  = 500000;

   // flat copy of the leaves; a range total is the plain sum of its leaves mod 2^64
   class sum_scoreboard;
      logic [SUM_W-1:0] leaf_val [LEAVES];
      logic [SUM_W-1:0] pending_sums [$];
      int unsigned      mismatches;
      int unsigned      sets_seen;
      int unsigned      queries_seen;
      int unsigned      empty_ranges;
      int unsigned      sums_checked;

      function new();
         foreach (leaf_val[i]) leaf_val[i] = '0;
      endfunction

      function logic [SUM_W-1:0] range_total(int unsigned lo, int unsigned hi);
         logic [SUM_W-1:0] acc;
         int unsigned      last_leaf;
         acc       = '0;
         // range end past the last leaf is clamped
         last_leaf = (hi >= LEAVES) ? LEAVES - 1 : hi;
         // lo above last_leaf leaves acc at zero: the empty range
         for (int unsigned p = lo; p <= last_leaf; p++) acc += leaf_val[p];
         return acc;
      endfunction

      function void note_beat(logic action, logic [POS_W-1:0] pos, logic [VAL_W-1:0] value,
                              logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
         if (action == ACT_SET) begin
            // out-of-range positions are dropped
            if (pos < LEAVES) leaf_val[pos] = {{(SUM_W-VAL_W){1'b0}}, value};
            sets_seen++;
         end else begin
            if (lo > hi) empty_ranges++;
            pending_sums.push_back(range_total(lo, hi));
            queries_seen++;
         end
      endfunction

      function void check_sum(logic [SUM_W-1:0] actual);
         logic [SUM_W-1:0] expected;
         if (pending_sums.size() == 0) begin
            $display("%0t: sum beat with none expected, actual %h", $time, actual);
            mismatches++;
            return;
         end
         expected = pending_sums.pop_front();
         sums_checked++;
         if (actual !== expected) begin
            $display("%0t: sum mismatch, expected %h actual %h", $time, expected, actual);
            mismatches++;
         end
      endfunction
   endclass

   // every input known from time zero
   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic             busy;
   logic             req_action     = ACT_SET;
   logic [POS_W-1:0] req_position   = '0;
   logic [VAL_W-1:0] req_value      = '0;
   logic [POS_W-1:0] req_range_low  = '0;
   logic [POS_W-1:0] req_range_high = '0;
   logic             rsp_valid;
   logic [SUM_W-1:0] rsp_sum;

   sum_scoreboard board = new();
   int unsigned   cycle_count   = 0;
   int unsigned   zero_gap_left = 0;

   always #CLK_HALF clock = ~clock;

   sum_segment_tree u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_sum        (rsp_sum)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("sum_segment_tree_tb failed");
         $finish;
      end
   end

   // result beats are taken at the edge that ends their strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) board.check_sum(rsp_sum);
   end

   // hold one beat on the request ports until the block takes it
   task automatic send_beat(logic action, logic [POS_W-1:0] pos, logic [VAL_W-1:0] value,
                            logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
      req_action     <= action;
      req_position   <= pos;
      req_value      <= value;
      req_range_low  <= lo;
      req_range_high <= hi;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_beat(action, pos, value, lo, hi);
   endtask

   // random gap after a beat: mostly none or short, a few long, with bursts of no gaps
   task automatic idle_after_beat();
      int unsigned gap;
      int unsigned pick;
      if (zero_gap_left > 0) begin
         zero_gap_left--;
         gap = 0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            zero_gap_left = $urandom_range(10, 40);
            gap = 0;
         end else if (pick < 55) gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 4);
         else if (pick < 96) gap = $urandom_range(5, 25);
         else gap = $urandom_range(26, 90);
      end
      if (gap > 0) begin
         // junk on the request ports while start is low
         start          <= 1'b0;
         req_action     <= 1'($urandom);
         req_position   <= POS_W'($urandom);
         req_value      <= $urandom;
         req_range_low  <= POS_W'($urandom);
         req_range_high <= POS_W'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every query has answered
   task automatic wait_for_sums();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_sums.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic             act;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] hi;
      logic [VAL_W-1:0] val;
      int unsigned      pick;
      int unsigned      span;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part; the first beat waits out the clearing pass
      send_beat(ACT_QUERY, 10'd7, 32'h1234_5678, 10'd0, 10'd1023);   // cleared tree sums to zero
      send_beat(ACT_SET, 10'd0, 32'hffff_ffff, 10'd1023, 10'd0);     // range fields are junk
      send_beat(ACT_SET, 10'd1023, 32'hffff_ffff, 10'd0, 10'd1023);
      send_beat(ACT_SET, 10'd512, 32'h0000_0001, 10'd5, 10'd4);
      send_beat(ACT_SET, 10'd511, 32'h8000_0000, 10'd0, 10'd0);
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023);           // whole tree
      send_beat(ACT_QUERY, 10'd1023, 32'hffff_ffff, 10'd0, 10'd0);   // first leaf only
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd1023, 10'd1023);        // last leaf only
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd511, 10'd512);          // straddles the halves
      send_beat(ACT_QUERY, 10'd3, 32'hdead_beef, 10'd5, 10'd4);      // empty range
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd1023, 10'd0);           // empty, widest inversion
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd1, 10'd1022);           // skips both outer leaves
      send_beat(ACT_SET, 10'd0, 32'h0000_0000, 10'd0, 10'd1023);     // overwrite with zero
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd0, 10'd1023);
      send_beat(ACT_SET, 10'd341, 32'h5555_5555, 10'd0, 10'd0);
      send_beat(ACT_SET, 10'd682, 32'haaaa_aaaa, 10'd0, 10'd0);
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd0, 10'd511);
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd512, 10'd1023);
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd341, 10'd682);
      send_beat(ACT_QUERY, 10'd0, 32'h0, 10'd342, 10'd681);
      wait_for_sums();

      // random part: sets and queries in about equal shares, every field random
      for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
         act = ($urandom_range(0, 1) == 0) ? ACT_SET : ACT_QUERY;
         pos = POS_W'($urandom);
         case ($urandom_range(0, 9))
            0:       val = '0;
            1:       val = '1;
            2:       val = $urandom_range(0, 15);
            default: val = $urandom;
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            // well-formed span
            lo = POS_W'($urandom);
            hi = POS_W'($urandom_range(lo, LEAVES - 1));
         end else if (pick < 6) begin
            // narrow window
            lo   = POS_W'($urandom);
            span = $urandom_range(0, 8);
            hi   = (lo + span > LEAVES - 1) ? POS_W'(LEAVES - 1) : POS_W'(lo + span);
         end else if (pick == 6) begin
            // full tree or one end of it
            lo = ($urandom_range(0, 1) == 0) ? '0 : POS_W'($urandom);
            hi = ($urandom_range(0, 1) == 0) ? POS_W'(LEAVES - 1) : POS_W'($urandom);
         end else if (pick < 9) begin
            lo = POS_W'($urandom);
            hi = POS_W'($urandom);
         end else begin
            // empty range
            lo = POS_W'($urandom_range(1, LEAVES - 1));
            hi = POS_W'($urandom_range(0, lo - 1));
         end
         send_beat(act, pos, val, lo, hi);
         if (i == RANDOM_BEATS / 2) wait_for_sums();
         else idle_after_beat();
      end

      // drain, then give a trailing set or stray beat time to show up
      start <= 1'b0;
      while (board.pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending_sums.size() != 0) begin
         $display("%0t: %0d sums never arrived, expected %h actual none", $time,
                  board.pending_sums.size(), board.pending_sums[0]);
         board.mismatches++;
      end

      $display("covered %0d set beats and %0d query beats, %0d of them empty ranges",
               board.sets_seen, board.queries_seen, board.empty_ranges);
      $display("%0d range sums compared, %0d mismatches", board.sums_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("sum_segment_tree_tb passed");
      end else begin
         $display("sum_segment_tree_tb failed");
      end
      $finish;
   end

endmodule
